// ===== hw/rtl/abkf_pkg.sv =====
// Shared constants, fixed-point widths and saturation helper for the
// angle/bias Kalman filter. No dependencies.
package abkf_pkg;

  localparam int COV_FRAC_BITS = 30;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int MUL_STEPS = 32;
  localparam int DIV_W = 32 + COV_FRAC_BITS;
  localparam int RND_W = 64 - COV_FRAC_BITS;

  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_ANGLE_NOISE = 2'd1;
  localparam logic [1:0] REG_BIAS_NOISE = 2'd2;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd3;

  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (COV_FRAC_BITS - 1);
  localparam logic signed [31:0] COV_ONE = 32'sd1 <<< COV_FRAC_BITS;

  typedef logic signed [31:0] word_t;

  function automatic word_t sat32(input logic signed [35:0] v);
    word_t res;
    if (v > 36'sh0_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/abkf_mul.sv =====
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on abkf_pkg.
module abkf_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [32:0]   mul_a,
  input  logic signed [31:0]   mul_b,
  output logic                 done,
  output logic signed [63:0]   prod
);
  import abkf_pkg::*;

  logic signed [34:0] hi_r, hi_nxt;
  logic [31:0]        lo_r, lo_nxt;
  logic signed [32:0] a_r;
  logic [4:0]         cnt_r;
  logic               busy_r, done_r;
  logic signed [34:0] addend, sum;
  logic [66:0]        full;

  always_comb begin
    addend = '0;
    if (lo_r[0]) begin
      addend = (cnt_r == 5'(MUL_STEPS - 1)) ? -35'(a_r) : 35'(a_r);
    end
    sum = hi_r + addend;
    hi_nxt = sum >>> 1;
    lo_nxt = {sum[0], lo_r[31:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r <= '0;
      lo_r <= mul_b;
      a_r <= mul_a;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign full = {hi_r, lo_r};
  assign prod = full[63:0];
  assign done = done_r;

endmodule

// ===== hw/rtl/abkf_div.sv =====
// Restoring divider, one quotient bit per cycle: sat(num * 2^F / den),
// truncated toward zero, den positive. Depends on abkf_pkg.
module abkf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic [31:0]        den,
  output logic               done,
  output logic signed [31:0] quo
);
  import abkf_pkg::*;

  logic [DIV_W-1:0] n_r, q_r;
  logic [31:0]      rem_r, den_r;
  logic             neg_r, busy_r, done_r;
  logic [5:0]       cnt_r;
  logic [32:0]      r2, diff;
  logic             ge;
  logic [31:0]      mag;

  assign mag = num[31] ? (~num + 32'd1) : num;
  assign r2 = {rem_r, n_r[DIV_W-1]};
  assign diff = r2 - {1'b0, den_r};
  assign ge = (r2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= {mag, {COV_FRAC_BITS{1'b0}}};
      q_r <= '0;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[31];
    end else if (busy_r) begin
      n_r <= {n_r[DIV_W-2:0], 1'b0};
      q_r <= {q_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[31:0] : r2[31:0];
    end
  end

  always_comb begin
    if (neg_r) begin
      if (q_r > DIV_W'(64'h8000_0000)) quo = 32'sh8000_0000;
      else quo = -q_r[31:0];
    end else begin
      if (q_r > DIV_W'(64'h7FFF_FFFF)) quo = 32'sh7FFF_FFFF;
      else quo = q_r[31:0];
    end
  end

  assign done = done_r;

endmodule

// ===== hw/rtl/angle_bias_kalman_filter.sv =====
// Top level of the two-state angle/gyro-bias Kalman filter for one axis.
// Depends on abkf_pkg, abkf_mul and abkf_div.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat carries an accelerometer
//   angle and a gyro rate, both signed Q16.16. Output channel
//   (out_valid/out_ready): one beat per input beat with the posterior angle
//   and the bias-corrected rate, signed Q16.16.
//   cfg_we/cfg_index/cfg_wdata write dt, Qa, Qg and R (unsigned Q1.30); write only
//   while the filter is idle.
//   Ten products go through one bit-serial multiplier, and two gains
//   through one restoring divider; the gains are skipped when R + P00
//   is not positive. One sample is processed at a time.
//   in_ready is high whenever no sample is being processed, so the next
//   sample is taken while a finished result waits on a stalled receiver;
//   the next result is held internally until the output register frees.
//   Reset: estimates clear, P becomes identity, registers take defaults.
module angle_bias_kalman_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_measured_angle,
  input  logic signed [31:0] in_gyro_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_filtered_angle,
  output logic signed [31:0] out_corrected_rate,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_wdata
);
  import abkf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  localparam logic [3:0] OP_ANGLE = 4'd0;
  localparam logic [3:0] OP_P00 = 4'd1;
  localparam logic [3:0] OP_P01 = 4'd2;
  localparam logic [3:0] OP_P11 = 4'd3;
  localparam logic [3:0] OP_K0 = 4'd4;
  localparam logic [3:0] OP_K1 = 4'd5;
  localparam logic [3:0] OP_U00 = 4'd6;
  localparam logic [3:0] OP_U01 = 4'd7;
  localparam logic [3:0] OP_U10 = 4'd8;
  localparam logic [3:0] OP_U11 = 4'd9;
  localparam logic [3:0] OP_UANG = 4'd10;
  localparam logic [3:0] OP_UBIAS = 4'd11;

  logic [30:0] dt_r, qa_r, qg_r, rn_r;
  word_t angle_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  word_t pp00_r, pp01_r, pp10_r, pp11_r, k0_r, k1_r, err_r;
  word_t meas_r, gyro_r, out_angle_r, out_rate_r;
  logic [1:0] state_r;
  logic [3:0] op_r;
  logic started_r, out_valid_r;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic mul_start, mul_done, div_start, div_done, is_div, den_pos;
  logic signed [63:0] prod, prod_rnd;
  logic signed [RND_W-1:0] rval;
  logic signed [31:0] quo, div_num;
  logic signed [32:0] den_full;
  word_t rdiff, pd0;

  assign rdiff = sat32(36'(gyro_r) - 36'(bias_r));
  assign pd0 = sat32(36'(signed'({1'b0, qa_r})) - 36'(p01_r) - 36'(p10_r));
  assign den_full = 33'(signed'({1'b0, rn_r})) + 33'(pp00_r);
  assign den_pos = !den_full[32] && (den_full != '0);
  assign is_div = (op_r == OP_K0) || (op_r == OP_K1);
  assign div_num = (op_r == OP_K0) ? pp00_r : pp10_r;

  always_comb begin
    mul_a = 33'(k0_r);
    mul_b = signed'({1'b0, dt_r});
    case (op_r)
      OP_ANGLE: mul_a = 33'(rdiff);
      OP_P00:   mul_a = 33'(pd0);
      OP_P01:   mul_a = -33'(p11_r);
      OP_P11:   mul_a = signed'({2'b0, qg_r});
      OP_U00: begin
        mul_a = 33'(k0_r);
        mul_b = pp00_r;
      end
      OP_U01: begin
        mul_a = 33'(k0_r);
        mul_b = pp01_r;
      end
      OP_U10: begin
        mul_a = 33'(k1_r);
        mul_b = pp00_r;
      end
      OP_U11: begin
        mul_a = 33'(k1_r);
        mul_b = pp01_r;
      end
      OP_UANG: begin
        mul_a = 33'(k0_r);
        mul_b = err_r;
      end
      OP_UBIAS: begin
        mul_a = 33'(k1_r);
        mul_b = err_r;
      end
      default: mul_a = 33'(k0_r);
    endcase
  end

  assign mul_start = (state_r == ST_RUN) && !started_r && !is_div;
  assign div_start = (state_r == ST_RUN) && !started_r && is_div && den_pos;

  abkf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  abkf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_full[31:0]),
    .done  (div_done),
    .quo   (quo)
  );

  assign prod_rnd = prod + RND_HALF;
  assign rval = prod_rnd[63:COV_FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= 31'd5368709;
      qa_r <= 31'd1073742;
      qg_r <= 31'd3221225;
      rn_r <= 31'd536870912;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:   dt_r <= cfg_wdata;
        REG_ANGLE_NOISE: qa_r <= cfg_wdata;
        REG_BIAS_NOISE:  qg_r <= cfg_wdata;
        REG_MEAS_NOISE:  rn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= OP_ANGLE;
      started_r <= 1'b0;
      out_valid_r <= 1'b0;
      angle_r <= '0;
      bias_r <= '0;
      p00_r <= COV_ONE;
      p01_r <= '0;
      p10_r <= '0;
      p11_r <= COV_ONE;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            meas_r <= in_measured_angle;
            gyro_r <= in_gyro_rate;
            op_r <= OP_ANGLE;
            started_r <= 1'b0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!started_r) begin
            if (is_div && !den_pos) begin
              k0_r <= '0;
              k1_r <= '0;
              op_r <= OP_U00;
            end else begin
              started_r <= 1'b1;
            end
          end else if (div_done) begin
            started_r <= 1'b0;
            if (op_r == OP_K0) k0_r <= quo;
            else k1_r <= quo;
            op_r <= op_r + 4'd1;
          end else if (mul_done) begin
            started_r <= 1'b0;
            op_r <= op_r + 4'd1;
            case (op_r)
              OP_ANGLE: angle_r <= sat32(36'(angle_r) + 36'(rval));
              OP_P00:   pp00_r <= sat32(36'(p00_r) + 36'(rval));
              OP_P01: begin
                pp01_r <= sat32(36'(p01_r) + 36'(rval));
                pp10_r <= sat32(36'(p10_r) + 36'(rval));
              end
              OP_P11: begin
                pp11_r <= sat32(36'(p11_r) + 36'(rval));
                err_r <= sat32(36'(meas_r) - 36'(angle_r));
              end
              OP_U00:   p00_r <= sat32(36'(pp00_r) - 36'(rval));
              OP_U01:   p01_r <= sat32(36'(pp01_r) - 36'(rval));
              OP_U10:   p10_r <= sat32(36'(pp10_r) - 36'(rval));
              OP_U11:   p11_r <= sat32(36'(pp11_r) - 36'(rval));
              OP_UANG:  angle_r <= sat32(36'(angle_r) + 36'(rval));
              OP_UBIAS: begin
                bias_r <= sat32(36'(bias_r) + 36'(rval));
                state_r <= ST_OUT;
              end
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_angle_r <= angle_r;
            out_rate_r <= rdiff;
            out_valid_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_filtered_angle = out_angle_r;
  assign out_corrected_rate = out_rate_r;

endmodule
